/* rtl/stereo_feedback_delay_line_unit_macros.svh */
// Assertion macros for the stereo feedback delay line unit.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef STEREO_FEEDBACK_DELAY_LINE_UNIT_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_LINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SFDL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SFDL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sfdl_pkg.sv */
// Package for the stereo feedback delay line unit: widths, register codes
// and request payload types. No dependencies.
package sfdl_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned LEVEL_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(5000);
  localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(65536);
  localparam logic [FRAC_W-1:0] FRAC_ONE   = FRAC_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH    = 2'd0,
    CFG_FEEDBACK_GAIN   = 2'd1,
    CFG_OFFSET_FRACTION = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       channel;
    logic                       block_start;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [LEVEL_W-1:0]         block_level;
  } out_req_t;

endpackage

/* rtl/stereo_feedback_delay_line_unit.sv */
// Stereo feedback delay line (echo) with per-block output level.
// Depends on sfdl_pkg and stereo_feedback_delay_line_unit_macros.svh.
//
//   channel   direction  handshake                    payload
//   in        request    in_valid_i / in_stall_o      in_req_t
//   out       result     out_valid_o / out_stall_i    out_req_t
//   cfg       write      cfg_we_i                     cfg_index_i, cfg_data_i
//
// Requests cannot be taken back to back: the C1 and C2 stages share the single
// read port of each store (entry at the write position, then delayed entry).
// A result passes through C1, C2 and C3 into a 2-entry result queue that lets new
// requests in while results wait. Input stalls while two requests are taken
// and not yet delivered, unless one of them leaves in that cycle.
// After reset both stores are cleared, one entry a cycle, with in_stall_o high
// until all 65536 entries are done. Configuration writes are taken throughout.
`include "stereo_feedback_delay_line_unit_macros.svh"

module stereo_feedback_delay_line_unit
  import sfdl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_req_t              out_req_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [SAMPLE_W-1:0] sat17(input logic signed [SAMPLE_W:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
      r = v[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------- configuration
  logic [LEN_W-1:0]  delay_length_q;
  logic [GAIN_W-1:0] feedback_gain_q;
  logic [FRAC_W-1:0] offset_fraction_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_length_q    <= LEN_RESET;
      feedback_gain_q   <= '0;
      offset_fraction_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DELAY_LENGTH:    delay_length_q    <= cfg_data_i[LEN_W-1:0];
        CFG_FEEDBACK_GAIN:   feedback_gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_OFFSET_FRACTION: offset_fraction_q <= cfg_data_i[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------- clearing pass
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (&clr_addr_q) clr_busy_q <= 1'b0;
    end
  end

  // ------------------------------------------------------------ handshake
  logic       in_accept, out_pop, push;
  logic [1:0] cnt_q, cnt_d;          // requests accepted and not yet delivered
  logic [1:0] fifo_cnt_q;
  logic       v1_q, v2_q, v3_q;

  assign out_valid_o = (fifo_cnt_q != 2'd0);
  assign out_pop     = out_valid_o && !out_stall_i;
  // C1 owns the read port, so no request enters while C1 holds one.
  assign in_stall_o  = clr_busy_q || v1_q || ((cnt_q == 2'd2) && !out_pop);
  assign in_accept   = in_valid_i && !in_stall_o;

  always_comb begin
    cnt_d = cnt_q;
    if (in_accept && !out_pop) cnt_d = cnt_q + 2'd1;
    if (!in_accept && out_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  // --------------------------------------------------------- stage C1
  // Reads the entry at the write position, advances the write position,
  // works out the left read offset.
  logic signed [SAMPLE_W-1:0] x1_q;
  logic                       ch1_q, st1_q;
  logic [ADDR_W-1:0]          wpos_l_q, wpos_r_q;
  logic [ADDR_W-1:0]          wp_c1;
  logic [LEN_W-1:0]           len_c1;
  logic [FRAC_W-1:0]          frac_c1;
  logic [LEN_W+FRAC_W-1:0]    prod_c1;
  logic [LEN_W-1:0]           wp_inc_c1;
  logic [ADDR_W-1:0]          wp_next_c1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= in_accept;
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x1_q  <= in_req_i.sample_in;
      ch1_q <= in_req_i.channel;
      st1_q <= in_req_i.block_start;
    end
  end

  always_comb begin
    wp_c1 = ch1_q ? wpos_r_q : wpos_l_q;
    // zero length acts as one, anything above the store depth as the depth
    if (delay_length_q == '0)         len_c1 = LEN_W'(1);
    else if (delay_length_q > LEN_MAX) len_c1 = LEN_MAX;
    else                               len_c1 = delay_length_q;
    frac_c1    = (offset_fraction_q > FRAC_ONE) ? FRAC_ONE : offset_fraction_q;
    prod_c1    = (LEN_W+FRAC_W)'(frac_c1) * (LEN_W+FRAC_W)'(len_c1);
    wp_inc_c1  = {1'b0, wp_c1} + LEN_W'(1);
    wp_next_c1 = (wp_inc_c1 >= len_c1) ? '0 : wp_inc_c1[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_l_q <= '0;
      wpos_r_q <= '0;
    end else if (v1_q) begin
      if (ch1_q) wpos_r_q <= wp_next_c1;
      else       wpos_l_q <= wp_next_c1;
    end
  end

  // --------------------------------------------------------- stage C2
  // Reads the delayed entry; old entry arrives and feeds the feedback multiply.
  logic signed [SAMPLE_W-1:0] x2_q;
  logic                       ch2_q, st2_q;
  logic [ADDR_W-1:0]          wp2_q;
  logic [LEN_W-1:0]           off2_q, len2_q;
  logic [LEN_W-1:0]           rp_full_c2;
  logic [ADDR_W-1:0]          rp_c2;
  logic signed [SAMPLE_W-1:0] rd_l_q, rd_r_q;
  logic                       fwd_q;
  logic signed [SAMPLE_W-1:0] fwd_data_q;
  logic signed [SAMPLE_W-1:0] old_c2;
  logic signed [SAMPLE_W:0]   sum_c2;
  logic signed [GAIN_W:0]     gain_c2;
  logic signed [SAMPLE_W+GAIN_W+1:0] p_c2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      x2_q   <= x1_q;
      ch2_q  <= ch1_q;
      st2_q  <= st1_q;
      wp2_q  <= wp_c1;
      off2_q <= prod_c1[LEN_W+15:16];
      len2_q <= len_c1;
    end
  end

  always_comb begin
    rp_full_c2 = {1'b0, wp2_q};
    if (!ch2_q) begin
      // left taps behind the write position, wrapping by the length
      if (off2_q > {1'b0, wp2_q}) rp_full_c2 = {1'b0, wp2_q} + len2_q - off2_q;
      else                        rp_full_c2 = {1'b0, wp2_q} - off2_q;
    end
    rp_c2   = rp_full_c2[ADDR_W-1:0];
    // previous request's write-back may hit this entry in the same cycle
    old_c2  = fwd_q ? fwd_data_q : (ch2_q ? rd_r_q : rd_l_q);
    sum_c2  = {old_c2[SAMPLE_W-1], old_c2} + {x2_q[SAMPLE_W-1], x2_q};
    gain_c2 = {1'b0, feedback_gain_q};
    p_c2    = sum_c2 * gain_c2;
  end

  // --------------------------------------------------------- stage C3
  // Delayed entry arrives; output, write-back, level.
  logic signed [SAMPLE_W-1:0] x3_q;
  logic                       ch3_q, st3_q;
  logic [ADDR_W-1:0]          wp3_q;
  logic signed [SAMPLE_W+GAIN_W:0] p3_q;
  logic signed [SAMPLE_W-1:0] dly_c3, y_c3, fb_c3;
  logic [SAMPLE_W:0]          mag_c3;
  logic [LEVEL_W-1:0]         level_q, base_c3, lvl_c3;
  logic [LEVEL_W:0]           lvl_sum_c3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      x3_q  <= x2_q;
      ch3_q <= ch2_q;
      st3_q <= st2_q;
      wp3_q <= wp2_q;
      p3_q  <= p_c2[SAMPLE_W+GAIN_W:0];
    end
  end

  always_comb begin
    dly_c3 = ch3_q ? rd_r_q : rd_l_q;
    y_c3   = sat17({x3_q[SAMPLE_W-1], x3_q} + {dly_c3[SAMPLE_W-1], dly_c3});
    // arithmetic shift floors toward minus infinity
    fb_c3  = sat17(p3_q[SAMPLE_W+GAIN_W:GAIN_W]);
    mag_c3 = y_c3[SAMPLE_W-1] ? (~{y_c3[SAMPLE_W-1], y_c3} + (SAMPLE_W+1)'(1))
                              : {1'b0, y_c3};
    base_c3    = st3_q ? '0 : level_q;
    lvl_sum_c3 = {1'b0, base_c3} + (LEVEL_W+1)'(mag_c3);
    lvl_c3     = lvl_sum_c3[LEVEL_W] ? '1 : lvl_sum_c3[LEVEL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)   level_q <= '0;
    else if (v3_q) level_q <= lvl_c3;
  end

  // --------------------------------------------------------------- stores
  logic signed [SAMPLE_W-1:0] mem_l_q [1<<ADDR_W];
  logic signed [SAMPLE_W-1:0] mem_r_q [1<<ADDR_W];
  logic                       we_l, we_r;
  logic [ADDR_W-1:0]          waddr, raddr;
  logic signed [SAMPLE_W-1:0] wdata;
  logic                       fwd_d;

  assign we_l  = clr_busy_q || (v3_q && !ch3_q);
  assign we_r  = clr_busy_q || (v3_q && ch3_q);
  assign waddr = clr_busy_q ? clr_addr_q : wp3_q;
  assign wdata = clr_busy_q ? '0 : fb_c3;
  assign raddr = v2_q ? rp_c2 : wp_c1;
  assign fwd_d = v1_q && v3_q && (ch3_q == ch1_q) && (wp3_q == wp_c1);

  always_ff @(posedge clk_i) begin
    if (we_l) mem_l_q[waddr] <= wdata;
    rd_l_q <= mem_l_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_r) mem_r_q[waddr] <= wdata;
    rd_r_q <= mem_r_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fwd_q <= 1'b0;
    else         fwd_q <= fwd_d;
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= fb_c3;
  end

  // --------------------------------------------------------- result queue
  out_req_t fifo_q [2];
  logic     wr_ptr_q, rd_ptr_q;

  assign push      = v3_q;
  assign out_req_o = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].sample_out  <= y_c3;
      fifo_q[wr_ptr_q].block_level <= lvl_c3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      fifo_cnt_q <= '0;
    end else begin
      if (push)    wr_ptr_q <= ~wr_ptr_q;
      if (out_pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !out_pop) fifo_cnt_q <= fifo_cnt_q + 2'd1;
      if (!push && out_pop) fifo_cnt_q <= fifo_cnt_q - 2'd1;
    end
  end

  // ----------------------------------------------------------- assertions
  `SFDL_ASSERT_IMP(a_no_accept_clr, clk_i, rst_ni, clr_busy_q, !in_accept, "accept while clearing")
  `SFDL_ASSERT_IMP(a_fifo_room, clk_i, rst_ni, push && !out_pop, fifo_cnt_q < 2'd2, "queue overflow")
  `SFDL_ASSERT_IMP(a_cnt_match, clk_i, rst_ni, 1'b1, 3'(cnt_q) == 3'(fifo_cnt_q) + 3'(v1_q) + 3'(v2_q) + 3'(v3_q), "in-flight count mismatch")
  `SFDL_ASSERT_IMP(a_fwd_stage, clk_i, rst_ni, fwd_q, v2_q, "forward without a C2 request")

endmodule

/* test/sfdl_echo_checker.sv */
`timescale 1ns / 1ps
// Checker for the stereo feedback delay line: watches the request, result and
// register ports, predicts each echo result and compares. Depends on sfdl_pkg.
module sfdl_echo_checker
  import sfdl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_req_t               in_req_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_req_t              out_req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           failures_o,
  output int unsigned           pending_o
);

  localparam int MAX_TAPS   = 65536;
  localparam int REPORT_MAX = 10;
  localparam longint Q15_HI = 32767;
  localparam longint Q15_LO = -32768;
  localparam longint LEVEL_SAT = 64'hFFFF_FFFF;

  logic signed [SAMPLE_W-1:0] left_taps  [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] right_taps [MAX_TAPS];
  int unsigned                left_wr;
  int unsigned                right_wr;
  logic [LEVEL_W-1:0]         level_acc;

  logic [LEN_W-1:0]  dly_len;
  logic [GAIN_W-1:0] fb_gain;
  logic [FRAC_W-1:0] fb_frac;

  out_req_t    echo_due [$];
  out_req_t    want;
  int unsigned n_bad = 0;
  int unsigned n_results = 0;

  assign failures_o = n_bad;

  function automatic longint clamp_q15(input longint v);
    if (v > Q15_HI) return Q15_HI;
    if (v < Q15_LO) return Q15_LO;
    return v;
  endfunction

  // Advances the predicted state by one request and returns its result.
  function automatic out_req_t echo_step(input in_req_t rq);
    longint   len, frac, off, wp, rp, x, dly, old, y, p, g, lvl;
    out_req_t res;
    len = dly_len;
    if (len == 0) len = 1;
    if (len > MAX_TAPS) len = MAX_TAPS;
    x = $signed(rq.sample_in);
    g = fb_gain;
    wp = rq.channel ? right_wr : left_wr;
    rp = wp;
    if (!rq.channel) begin
      frac = fb_frac;
      if (frac > 65536) frac = 65536;
      off = (frac * len) >> 16;
      rp = (off > wp) ? wp + len - off : wp - off;
    end
    if (rq.channel) begin
      dly = right_taps[rp];
      old = right_taps[wp];
    end else begin
      dly = left_taps[rp];
      old = left_taps[wp];
    end
    y = clamp_q15(x + dly);
    p = (old + x) * g;
    // arithmetic shift floors towards minus infinity
    if (rq.channel) right_taps[wp] = SAMPLE_W'(clamp_q15(p >>> 16));
    else            left_taps[wp]  = SAMPLE_W'(clamp_q15(p >>> 16));
    if (rq.channel) right_wr = (wp + 1 >= len) ? 0 : int'(wp + 1);
    else            left_wr  = (wp + 1 >= len) ? 0 : int'(wp + 1);
    if (rq.block_start) level_acc = '0;
    lvl = level_acc;
    lvl = lvl + ((y < 0) ? -y : y);
    if (lvl > LEVEL_SAT) lvl = LEVEL_SAT;
    level_acc = lvl[LEVEL_W-1:0];
    res.sample_out  = y[SAMPLE_W-1:0];
    res.block_level = level_acc;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        left_taps[i]  = '0;
        right_taps[i] = '0;
      end
      left_wr   = 0;
      right_wr  = 0;
      level_acc = '0;
      dly_len   = LEN_RESET;
      fb_gain   = '0;
      fb_frac   = '0;
      echo_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DELAY_LENGTH:    dly_len = cfg_data_i[LEN_W-1:0];
          CFG_FEEDBACK_GAIN:   fb_gain = cfg_data_i[GAIN_W-1:0];
          CFG_OFFSET_FRACTION: fb_frac = cfg_data_i[FRAC_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (echo_due.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_MAX)
            $display("result %0d with no request waiting: sample_out %0d block_level %0d",
                     n_results, $signed(out_req_i.sample_out), out_req_i.block_level);
        end else begin
          want = echo_due.pop_front();
          if (out_req_i !== want) begin
            n_bad++;
            if (n_bad <= REPORT_MAX)
              $display("result %0d mismatch: sample_out exp %0d got %0d, block_level exp %0d got %0d",
                       n_results, $signed(want.sample_out), $signed(out_req_i.sample_out),
                       want.block_level, out_req_i.block_level);
          end
        end
        n_results++;
      end
      if (in_valid_i && !in_stall_i) echo_due.push_back(echo_step(in_req_i));
      pending_o <= echo_due.size();
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Top of the stereo echo testbench: clock, reset, request and register
// stimulus and the verdict. Depends on sfdl_pkg, the unit and sfdl_echo_checker.
module tb_top;
  import sfdl_pkg::*;

  localparam int          HOLD_CYCLES  = 400;       // long receiver hold-off
  localparam int unsigned LIMIT_CYCLES = 1_500_000; // timeout, well past slowest run
  localparam int          PHASE_ITEMS  = 125;
  localparam int          SOAK_ITEMS   = 16;        // short full-scale run before a block start
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3; // unmapped index, must be ignored
  localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;
  localparam logic LEFT  = 1'b0;
  localparam logic RIGHT = 1'b1;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_req_t               in_req = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_req_t              out_req;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned failures;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        holding = 1'b0;
  event        hold_start;

  stereo_feedback_delay_line_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  sfdl_echo_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_req_i   (out_req),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .failures_o  (failures),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // Timeout: a hung handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver side: random stalls, or solid stall while a hold-off runs.
  always @(posedge clk_i) begin
    if (holding) out_stall <= 1'b1;
    else         out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Hold-off counter in its own process; the sender keeps offering requests
  // meanwhile, so the result queue fills and the unit stalls its input.
  always begin
    @(hold_start);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    holding <= 1'b0;
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default:   begin send_idle_pct = 28; recv_stall_pct = 28; end
    endcase
  endtask

  // Offers one request and returns at the edge where it is taken. Valid is
  // left high so back-to-back requests need no second assignment per step.
  task automatic send_req(input logic signed [SAMPLE_W-1:0] smp, input logic ch,
                          input logic bs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_req   <= '{sample_in: smp, channel: ch, block_start: bs};
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Waits until every request taken has produced its result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Writes all three registers plus the spare index; only called when idle.
  task automatic configure(input logic [LEN_W-1:0] len, input logic [GAIN_W-1:0] gain,
                           input logic [FRAC_W-1:0] frac);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DELAY_LENGTH;
    cfg_data  <= len;
    @(posedge clk_i);
    cfg_index <= CFG_FEEDBACK_GAIN;
    cfg_data  <= CFG_DATA_W'(gain);
    @(posedge clk_i);
    cfg_index <= CFG_OFFSET_FRACTION;
    cfg_data  <= frac;
    @(posedge clk_i);
    cfg_index <= CFG_SPARE;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_config();
    logic [LEN_W-1:0]  len;
    logic [GAIN_W-1:0] gain;
    logic [FRAC_W-1:0] frac;
    // short lengths mostly, so echoes actually come round within a phase
    case ($urandom_range(9))
      0:       len = '0;
      1:       len = LEN_MAX;
      2:       len = '1;
      3:       len = LEN_W'($urandom_range(5000, 17));
      default: len = LEN_W'($urandom_range(16, 1));
    endcase
    case ($urandom_range(4))
      0:       gain = '0;
      1:       gain = GAIN_W'(64880);
      2:       gain = '1;
      default: gain = GAIN_W'($urandom);
    endcase
    case ($urandom_range(5))
      0:       frac = '0;
      1:       frac = FRAC_ONE;
      2:       frac = '1;
      3:       frac = FRAC_W'($urandom);
      default: frac = FRAC_W'($urandom_range(65536));
    endcase
    configure(len, gain, frac);
  endtask

  task automatic random_req();
    logic signed [SAMPLE_W-1:0] smp;
    case ($urandom_range(7))
      0:       smp = Q15_MAX;
      1:       smp = Q15_MIN;
      2:       smp = SAMPLE_W'($urandom_range(15)) - SAMPLE_W'(8);
      default: smp = SAMPLE_W'($urandom);
    endcase
    send_req(smp, 1'($urandom_range(1)), ($urandom_range(9) == 0));
  endtask

  initial begin
    set_idling(IDLE_NONE);
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset settings: long delay, so outputs are just the inputs.
    send_req(Q15_MAX, LEFT, 1'b1);
    send_req(Q15_MIN, RIGHT, 1'b0);
    send_req('0, LEFT, 1'b0);
    send_req(-16'sd1, RIGHT, 1'b0);
    drain();

    // Short delay, high gain, half offset: stores build up and both
    // saturation directions of the output are reached.
    configure(LEN_W'(3), GAIN_W'(64880), FRAC_W'(32768));
    repeat (4) send_req(Q15_MAX, LEFT, 1'b0);
    repeat (3) send_req(Q15_MIN, RIGHT, 1'b0);
    send_req(Q15_MIN, RIGHT, 1'b1);
    drain();

    // Zero length acts as one; full offset reads at the write position.
    configure('0, '1, FRAC_ONE);
    send_req(16'sd1000, LEFT, 1'b0);
    send_req(-16'sd1000, RIGHT, 1'b0);
    send_req(16'sd5, LEFT, 1'b1);
    drain();

    // Over-range length and offset both clamp.
    configure('1, GAIN_W'(32768), '1);
    for (int i = 0; i < 6; i++) send_req(SAMPLE_W'(100 * (i + 1)), 1'(i), 1'b0);
    drain();

    // Shorten the length below the write positions: next access sits past
    // the end, then wraps to zero.
    configure(LEN_W'(2), '0, FRAC_W'(16384));
    send_req(16'sd7, LEFT, 1'b0);
    send_req(16'sd8, LEFT, 1'b0);
    send_req(16'sd9, RIGHT, 1'b0);
    send_req(-16'sd9, RIGHT, 1'b0);
    drain();

    // Random phases cycling through the idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      set_idling(idle_mode_e'(ph % 4));
      random_config();
      if (ph == 0) -> hold_start;
      for (int i = 0; i < PHASE_ITEMS; i++) random_req();
      drain();
    end

    // Full-scale run with no feedback, then one block start to clear the level.
    set_idling(IDLE_NONE);
    configure(LEN_W'(1), '0, '0);
    for (int i = 0; i < SOAK_ITEMS; i++) send_req(Q15_MIN, 1'($urandom_range(1)), (i == 0));
    send_req(16'sd100, LEFT, 1'b1);
    drain();

    repeat (8) @(posedge clk_i);
    if (failures == 0) $display("Verification passed");
    else               $display("Verification failed");
    $finish;
  end

endmodule
